// File: hw/rtl/rgb_convolve_2d_clamped_assert.svh
// assertion macros for the rgb convolution block
// no dependencies; included by modules that carry assertions
`ifndef RGB_CONVOLVE_2D_CLAMPED_ASSERT_SVH
`define RGB_CONVOLVE_2D_CLAMPED_ASSERT_SVH

// property must hold at every clock edge outside reset
`define RCC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rcc assertion failed");

// condition must never be true
`define RCC_NEVER(label, clk, rst_n, cond) \
  `RCC_ASSERT(label, clk, rst_n, !(cond))

`endif

// File: hw/rtl/rcc_pkg.sv
// shared types and constants of the rgb convolution block
// no dependencies
package rcc_pkg;

  localparam int unsigned MaxKernel = 7;
  localparam int unsigned MaxReach  = MaxKernel / 2;
  localparam int unsigned TableSize = MaxKernel * MaxKernel;
  localparam int unsigned MaxWidth  = 2048;
  localparam int unsigned MaxHeight = 2048;
  localparam int unsigned ColW      = 11;
  localparam int unsigned RowW      = 11;
  localparam int unsigned RowSlots  = 2 * MaxKernel;
  localparam int unsigned SlotW     = 4;
  localparam int unsigned AddrW     = SlotW + ColW;
  localparam int unsigned CoefBits  = 16;
  localparam int unsigned FracBits  = 12;
  localparam int unsigned AccW      = 30;
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QPtrW     = 2;

  typedef enum logic [1:0] {
    KIND_COEF  = 2'd0,
    KIND_PIXEL = 2'd1,
    KIND_DRAIN = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    REG_KERNEL_WIDTH  = 3'd0,
    REG_KERNEL_HEIGHT = 3'd1,
    REG_IMAGE_WIDTH   = 3'd2,
    REG_IMAGE_HEIGHT  = 3'd3
  } reg_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  coef_index;
    logic signed [15:0] coef_value;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [10:0] out_column;
    logic [10:0] out_row;
    logic        frame_end;
  } out_item_t;

  // frame geometry, already clamped
  typedef struct packed {
    logic [ColW-1:0] w_m1;
    logic [RowW-1:0] h_m1;
    logic [1:0]      rx;
    logic [1:0]      ry;
  } geom_t;

  // work handed from front to back
  typedef struct packed {
    logic                is_coef;
    logic [5:0]          coef_index;
    logic [CoefBits-1:0] coef_value;
    logic [RowW-1:0]     row;
    logic [ColW-1:0]     col;
    logic [SlotW-1:0]    slot;
    logic                last;
  } job_t;

  // pixel write into the row store
  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [23:0]      data;
  } pix_wr_t;

endpackage

// File: hw/rtl/rcc_front.sv
// front end: config registers, raster counters, pixel writes and job issue
// depends on rcc_pkg
module rcc_front import rcc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_data_i,
  input  logic     cfg_valid_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  input  logic     q_full_i,
  output logic     push_o,
  output job_t     job_o,
  output pix_wr_t  pix_wr_o,
  output geom_t    geom_o
);

  logic [2:0]  kw_q, kh_q;
  logic [11:0] iw_q, ih_q;
  logic [ColW-1:0]  in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RowW-1:0]  in_row_q, in_row_d, out_row_q, out_row_d;
  logic [SlotW-1:0] in_slot_q, in_slot_d, out_slot_q, out_slot_d;
  logic done_q, done_d;
  logic acc, pix_wr, eval, emit, last, coef_ok, ready_out;
  logic [ColW-1:0] w_m1, need_c;
  logic [RowW-1:0] h_m1, need_r;
  logic [ColW:0] sum_c;
  logic [RowW:0] sum_r;

  always_comb begin
    if (iw_q == 12'd0) w_m1 = '0;
    else if (iw_q > 12'(MaxWidth)) w_m1 = ColW'(MaxWidth - 1);
    else w_m1 = ColW'(iw_q - 12'd1);
    if (ih_q == 12'd0) h_m1 = '0;
    else if (ih_q > 12'(MaxHeight)) h_m1 = RowW'(MaxHeight - 1);
    else h_m1 = RowW'(ih_q - 12'd1);
  end

  assign geom_o = '{w_m1: w_m1, h_m1: h_m1, rx: kw_q[2:1], ry: kh_q[2:1]};

  assign in_stall_o = q_full_i;
  assign acc = in_valid_i && !q_full_i;

  // row slots keep rolling across frames, so the tail rows of one frame
  // survive while the next frame starts filling the store
  always_comb begin
    pix_wr   = acc && (in_data_i.kind == KIND_PIXEL) && !done_q;
    in_col_d = in_col_q;
    in_row_d = in_row_q;
    in_slot_d = in_slot_q;
    done_d   = done_q;
    if (pix_wr) begin
      if (in_col_q == w_m1) begin
        in_col_d = '0;
        in_slot_d = (in_slot_q == SlotW'(RowSlots - 1)) ? '0 : in_slot_q + 1'b1;
        if (in_row_q == h_m1) begin
          in_row_d = '0;
          done_d = 1'b1;
        end else begin
          in_row_d = in_row_q + 1'b1;
        end
      end else begin
        in_col_d = in_col_q + 1'b1;
      end
    end
    sum_r  = {1'b0, out_row_q} + {{(RowW-1){1'b0}}, kh_q[2:1]};
    need_r = (sum_r > {1'b0, h_m1}) ? h_m1 : sum_r[RowW-1:0];
    sum_c  = {1'b0, out_col_q} + {{(ColW-1){1'b0}}, kw_q[2:1]};
    need_c = (sum_c > {1'b0, w_m1}) ? w_m1 : sum_c[ColW-1:0];
    ready_out = done_d || (in_row_d > need_r) || (in_row_d == need_r && in_col_d > need_c);
    eval = acc && (in_data_i.kind == KIND_PIXEL || in_data_i.kind == KIND_DRAIN);
    emit = eval && ready_out;
    last = (out_row_q == h_m1) && (out_col_q == w_m1);
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    out_slot_d = out_slot_q;
    if (emit) begin
      if (last) begin
        out_col_d = '0;
        out_row_d = '0;
        out_slot_d = (out_slot_q == SlotW'(RowSlots - 1)) ? '0 : out_slot_q + 1'b1;
        done_d = 1'b0;
      end else if (out_col_q == w_m1) begin
        out_col_d = '0;
        out_row_d = out_row_q + 1'b1;
        out_slot_d = (out_slot_q == SlotW'(RowSlots - 1)) ? '0 : out_slot_q + 1'b1;
      end else begin
        out_col_d = out_col_q + 1'b1;
      end
    end
    coef_ok = acc && (in_data_i.kind == KIND_COEF) && (in_data_i.coef_index < 6'(TableSize));
  end

  assign push_o = coef_ok || emit;
  assign job_o = '{is_coef: coef_ok, coef_index: in_data_i.coef_index,
                   coef_value: in_data_i.coef_value, row: out_row_q, col: out_col_q,
                   slot: out_slot_q, last: last};
  assign pix_wr_o = '{en: pix_wr, addr: {in_slot_q, in_col_q},
                      data: {in_data_i.blue_in, in_data_i.green_in, in_data_i.red_in}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kw_q <= 3'd3;
      kh_q <= 3'd3;
      iw_q <= 12'd640;
      ih_q <= 12'd480;
      in_col_q <= '0; in_row_q <= '0; in_slot_q <= '0;
      out_col_q <= '0; out_row_q <= '0; out_slot_q <= '0;
      done_q <= 1'b0;
    end else if (cfg_valid_i && cfg_index_i <= REG_IMAGE_HEIGHT) begin
      case (cfg_index_i)
        REG_KERNEL_WIDTH:  kw_q <= cfg_data_i[2:0];
        REG_KERNEL_HEIGHT: kh_q <= cfg_data_i[2:0];
        REG_IMAGE_WIDTH:   iw_q <= cfg_data_i;
        REG_IMAGE_HEIGHT:  ih_q <= cfg_data_i;
        default: ;
      endcase
      in_col_q <= '0; in_row_q <= '0; in_slot_q <= '0;
      out_col_q <= '0; out_row_q <= '0; out_slot_q <= '0;
      done_q <= 1'b0;
    end else begin
      in_col_q <= in_col_d; in_row_q <= in_row_d; in_slot_q <= in_slot_d;
      out_col_q <= out_col_d; out_row_q <= out_row_d; out_slot_q <= out_slot_d;
      done_q <= done_d;
    end
  end

endmodule

// File: hw/rtl/rcc_queue.sv
// short job queue between front and back end
// depends on rcc_pkg
module rcc_queue import rcc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  output logic avail_o,
  input  logic pop_i,
  output job_t job_o
);

  job_t ent_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QPtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (QPtrW+1)'(QDepth));
  assign avail_o = (cnt_q != '0);
  assign job_o   = ent_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      case ({push_i, pop_i})
        2'b10: cnt_q <= cnt_q + 1'b1;
        2'b01: cnt_q <= cnt_q - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wr_q] <= job_i;
  end

endmodule

// File: hw/rtl/rcc_back.sv
// back end: row store, coefficient table, tap walk with multiply-accumulate
// depends on rcc_pkg and rgb_convolve_2d_clamped_assert.svh
`include "rgb_convolve_2d_clamped_assert.svh"
module rcc_back import rcc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pix_wr_t   pix_wr_i,
  input  geom_t     geom_i,
  input  logic      avail_i,
  input  job_t      job_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT} state_e;

  state_e state_q;
  logic [23:0] store_q [RowSlots * MaxWidth];
  logic [CoefBits-1:0] ctab_q [TableSize];
  logic [TableSize-1:0] cvalid_q;
  job_t job_q;
  logic [2:0] ty_q, tx_q;
  logic v1_q, v2_q, out_valid_q;
  logic [23:0] pix_q;
  logic signed [CoefBits-1:0] coef_q;
  logic signed [24:0] p_q [3];
  logic signed [AccW-1:0] acc_q [3];
  out_item_t out_q;
  logic signed [12:0] r_s, c_s, slot_s;
  logic [RowW-1:0] rc;
  logic [ColW-1:0] cc;
  logic [SlotW-1:0] slot;
  logic [5:0] kidx;
  logic issue, tx_end, ty_end, wait_done;
  logic [7:0] sat [3];
  logic [AccW-1-FracBits:0] qv;

  // the next job may start while a finished result still waits to be taken
  assign pop_o = (state_q == ST_IDLE) && avail_i;
  assign issue = (state_q == ST_RUN);
  assign tx_end = (tx_q == {geom_i.rx, 1'b0});
  assign ty_end = (ty_q == {geom_i.ry, 1'b0});
  assign wait_done = (state_q == ST_WAIT) && !v1_q && !v2_q &&
                     (!out_valid_q || !out_stall_i);

  // replicated border: clamp tap position into the frame
  always_comb begin
    r_s = $signed({2'b0, job_q.row}) + $signed({10'b0, ty_q}) - $signed({11'b0, geom_i.ry});
    c_s = $signed({2'b0, job_q.col}) + $signed({10'b0, tx_q}) - $signed({11'b0, geom_i.rx});
    if (r_s < 0) rc = '0;
    else if (r_s > $signed({2'b0, geom_i.h_m1})) rc = geom_i.h_m1;
    else rc = r_s[RowW-1:0];
    if (c_s < 0) cc = '0;
    else if (c_s > $signed({2'b0, geom_i.w_m1})) cc = geom_i.w_m1;
    else cc = c_s[ColW-1:0];
    slot_s = $signed({9'b0, job_q.slot}) + $signed({2'b0, rc}) - $signed({2'b0, job_q.row});
    if (slot_s < 0) slot_s = slot_s + 13'sd14;
    else if (slot_s >= 13'sd14) slot_s = slot_s - 13'sd14;
    slot = slot_s[SlotW-1:0];
    kidx = 6'({3'b0, ty_q} * 6'(MaxKernel)) + {3'b0, tx_q};
  end

  always_ff @(posedge clk_i) begin
    if (pix_wr_i.en) store_q[pix_wr_i.addr] <= pix_wr_i.data;
    if (issue) begin
      pix_q <= store_q[{slot, cc}];
      coef_q <= cvalid_q[kidx] ? ctab_q[kidx] : '0;
    end
    if (pop_o && job_i.is_coef) ctab_q[job_i.coef_index] <= job_i.coef_value;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      p_q[i] <= $signed({1'b0, pix_q[8*i +: 8]}) * coef_q;
    end
    if (pop_o) job_q <= job_i;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qv = acc_q[i][AccW-1:FracBits];
      if (acc_q[i] < 0) sat[i] = 8'd0;
      else if (qv > 18'd255) sat[i] = 8'd255;
      else sat[i] = qv[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cvalid_q <= '0;
      ty_q <= '0;
      tx_q <= '0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) acc_q[i] <= '0;
      out_q <= '0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      if (!wait_done && out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (v2_q) begin
        for (int i = 0; i < 3; i++) acc_q[i] <= acc_q[i] + AccW'(p_q[i]);
      end
      case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            if (job_i.is_coef) begin
              cvalid_q[job_i.coef_index] <= 1'b1;
            end else begin
              ty_q <= '0;
              tx_q <= '0;
              for (int i = 0; i < 3; i++) acc_q[i] <= '0;
              state_q <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (tx_end) begin
            tx_q <= '0;
            if (ty_end) state_q <= ST_WAIT;
            else ty_q <= ty_q + 1'b1;
          end else begin
            tx_q <= tx_q + 1'b1;
          end
        end
        ST_WAIT: begin
          if (wait_done) begin
            out_valid_q <= 1'b1;
            out_q <= '{red_out: sat[0], green_out: sat[1], blue_out: sat[2],
                       out_column: job_q.col, out_row: job_q.row,
                       frame_end: job_q.last};
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `RCC_NEVER(a_no_overwrite, clk_i, rst_ni, wait_done && out_valid_q && out_stall_i)
  `RCC_ASSERT(a_pipe_follows, clk_i, rst_ni, v1_q |=> v2_q)
  `RCC_NEVER(a_pop_idle, clk_i, rst_ni, pop_o && state_q != ST_IDLE)

endmodule

// File: hw/rtl/rgb_convolve_2d_clamped.sv
// top level of the streaming rgb 2-d convolution with replicated borders
// depends on rcc_pkg, rcc_front, rcc_queue, rcc_back
// applies one odd kernel (up to 7x7, signed q.12 coefficients) to each of the
// red, green and blue channels of a raster pixel stream; taps past the frame
// edge read the nearest edge pixel, and each channel sum is clamped to 0..255
// after its fraction bits are dropped. the front end takes one request per
// cycle while the job queue has room, writes pixels into a 14-row store and
// queues up to four jobs; the back end walks the kernel taps with one
// row-store read per cycle, and the next job runs while a finished result
// waits in the output register. results lag their input by kernel_height/2
// rows plus kernel_width/2 pixels; drain requests flush the frame tail. no
// clearing pass is needed after reset
module rgb_convolve_2d_clamped import rcc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);

  logic    q_full, q_avail, push, pop;
  job_t    job_in, job_out;
  pix_wr_t pix_wr;
  geom_t   geom;

  // config writes are always taken
  assign cfg_ready_o = 1'b1;

  rcc_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .q_full_i(q_full), .push_o(push), .job_o(job_in),
    .pix_wr_o(pix_wr), .geom_o(geom)
  );

  rcc_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .job_i(job_in), .full_o(q_full),
    .avail_o(q_avail), .pop_i(pop), .job_o(job_out)
  );

  rcc_back u_back (
    .clk_i, .rst_ni, .pix_wr_i(pix_wr), .geom_i(geom), .avail_i(q_avail),
    .job_i(job_out), .pop_o(pop), .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule

// File: dv/rgb_convolve_2d_clamped_test.sv
// self-checking testbench for the streaming rgb 2-d convolution block
// depends on rcc_pkg and rgb_convolve_2d_clamped; holds its own line-buffer predictor
module rgb_convolve_2d_clamped_test;
  import rcc_pkg::*;

  localparam int unsigned CycleLimit = 3_000_000;
  // outlasts a 7x7 result in the back end, so this covers any work in flight
  localparam int unsigned DrainWait  = 120;

  // predictor and store of expected filtered pixels
  class conv_scoreboard;
    logic [15:0] coef_tab [TableSize];
    logic [23:0] pix_rows [RowSlots*MaxWidth];
    int unsigned in_col, in_row, px_col, px_row;
    bit          in_done;
    int unsigned kw, kh, img_w, img_h;
    out_item_t   pending_q[$];
    int unsigned results_made;
    int          errors;

    function new();
      foreach (coef_tab[i]) coef_tab[i] = '0;
      foreach (pix_rows[i]) pix_rows[i] = '0;
      kw = 3;
      kh = 3;
      img_w = 640;
      img_h = 480;
      restart();
    endfunction

    function void restart();
      in_col = 0;
      in_row = 0;
      px_col = 0;
      px_row = 0;
      in_done = 0;
    endfunction

    function int unsigned dim(int unsigned v, int unsigned top);
      return (v < 1) ? 1 : ((v > top) ? top : v);
    endfunction

    function int unsigned reach(int unsigned size);
      return ((size >> 1) > MaxReach) ? MaxReach : (size >> 1);
    endfunction

    function logic [7:0] clamp_byte(longint s);
      longint q;
      if (s < 0) return 8'd0;
      q = s >>> FracBits;
      return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    function void write_reg(logic [2:0] idx, logic [11:0] val);
      case (idx)
        REG_KERNEL_WIDTH:  kw = val[2:0];
        REG_KERNEL_HEIGHT: kh = val[2:0];
        REG_IMAGE_WIDTH:   img_w = val;
        REG_IMAGE_HEIGHT:  img_h = val;
        default: return;
      endcase
      restart();
    endfunction

    // an accepted request: update state and maybe expect one pixel
    function void note_request(in_item_t it);
      int unsigned w, h, rx, ry, need_r, need_c;
      int          r, c, dy, dx;
      longint      sum [3];
      longint      k;
      logic [23:0] p;
      out_item_t   e;
      bit          last;
      w = dim(img_w, MaxWidth);
      h = dim(img_h, MaxHeight);
      rx = reach(kw);
      ry = reach(kh);
      if (it.kind == KIND_COEF) begin
        if (it.coef_index < TableSize) coef_tab[it.coef_index] = it.coef_value;
        return;
      end
      if (it.kind == KIND_NONE) return;
      if (it.kind == KIND_PIXEL && !in_done) begin
        pix_rows[(in_row % RowSlots) * MaxWidth + in_col] =
          {it.blue_in, it.green_in, it.red_in};
        in_col++;
        if (in_col >= w) begin
          in_col = 0;
          in_row++;
          if (in_row >= h) begin
            in_row = 0;
            in_done = 1;
          end
        end
      end
      need_r = (px_row + ry > h - 1) ? h - 1 : px_row + ry;
      need_c = (px_col + rx > w - 1) ? w - 1 : px_col + rx;
      if (!in_done && in_row * w + in_col <= need_r * w + need_c) return;
      sum[0] = 0;
      sum[1] = 0;
      sum[2] = 0;
      for (dy = -int'(ry); dy <= int'(ry); dy++) begin
        r = int'(px_row) + dy;
        if (r < 0) r = 0;
        if (r > int'(h) - 1) r = int'(h) - 1;
        for (dx = -int'(rx); dx <= int'(rx); dx++) begin
          c = int'(px_col) + dx;
          if (c < 0) c = 0;
          if (c > int'(w) - 1) c = int'(w) - 1;
          p = pix_rows[(r % RowSlots) * MaxWidth + c];
          k = longint'($signed(coef_tab[(dy + ry) * MaxKernel + dx + rx]));
          sum[0] += longint'(p[7:0]) * k;
          sum[1] += longint'(p[15:8]) * k;
          sum[2] += longint'(p[23:16]) * k;
        end
      end
      last = (px_row == h - 1) && (px_col == w - 1);
      e.red_out = clamp_byte(sum[0]);
      e.green_out = clamp_byte(sum[1]);
      e.blue_out = clamp_byte(sum[2]);
      e.out_column = px_col[10:0];
      e.out_row = px_row[10:0];
      e.frame_end = last;
      pending_q.push_back(e);
      results_made++;
      if (last) begin
        px_col = 0;
        px_row = 0;
        in_done = 0;
      end else begin
        px_col++;
        if (px_col >= w) begin
          px_col = 0;
          px_row++;
        end
      end
    endfunction

    function void cmp(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s expected %0d actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending_q.size() == 0) begin
        $error("result with nothing expected: col %0d row %0d",
               got.out_column, got.out_row);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      cmp("red_out", e.red_out, got.red_out);
      cmp("green_out", e.green_out, got.green_out);
      cmp("blue_out", e.blue_out, got.blue_out);
      cmp("out_column", e.out_column, got.out_column);
      cmp("out_row", e.out_row, got.out_row);
      cmp("frame_end", e.frame_end, got.frame_end);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_data_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [11:0] cfg_data_i;

  conv_scoreboard pixel_sb;
  bit             idle_on;
  int unsigned    cycles;
  int unsigned    rand_pixels;

  rgb_convolve_2d_clamped dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // give up on a hung block
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side: check accepted pixels, stall in random bursts
  initial begin
    int unsigned burst;
    burst = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) pixel_sb.check_result(out_data_o);
      if (idle_on && burst == 0 && $urandom_range(0, 5) == 0) burst = $urandom_range(1, 13);
      if (burst > 0) begin
        out_stall_i <= 1'b1;
        burst--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // one request, held until the block takes it
  task automatic send_request(in_item_t it);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pixel_sb.note_request(it);
  endtask

  function automatic in_item_t make_request(kind_e k);
    in_item_t it;
    it = in_item_t'(48'({$urandom, $urandom}));
    it.kind = k;
    return it;
  endfunction

  task automatic load_coef(int unsigned idx, logic [15:0] val);
    in_item_t it;
    it = make_request(KIND_COEF);
    it.coef_index = idx[5:0];
    it.coef_value = val;
    send_request(it);
  endtask

  // coefficient shapes: full range, small signed, or mostly positive
  function automatic logic [15:0] pick_coef();
    case ($urandom_range(0, 2))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 2048)) - 1024);
      default: return 16'($urandom_range(0, 2048));
    endcase
  endfunction

  // wait until every expected pixel is out and the back end has gone quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pixel_sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [11:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    pixel_sb.write_reg(idx, val);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // one whole frame: geometry, some coefficients, pixels, then the tail
  task automatic run_frame(int unsigned kw, int unsigned kh, int unsigned w,
                           int unsigned h, int unsigned n_coef, bit noise);
    int unsigned total, start, n;
    in_item_t    it;
    settle();
    write_cfg(REG_KERNEL_WIDTH, 12'(kw));
    write_cfg(REG_KERNEL_HEIGHT, 12'(kh));
    write_cfg(REG_IMAGE_WIDTH, 12'(w));
    write_cfg(REG_IMAGE_HEIGHT, 12'(h));
    repeat (n_coef) load_coef($urandom_range(0, TableSize - 1), pick_coef());
    total = pixel_sb.dim(w, MaxWidth) * pixel_sb.dim(h, MaxHeight);
    start = pixel_sb.results_made;
    for (n = 0; n < total; n++) begin
      if (noise && $urandom_range(0, 19) == 0) begin
        case ($urandom_range(0, 2))
          0: send_request(make_request(KIND_NONE));
          1: load_coef($urandom_range(TableSize, 63), pick_coef());
          default: load_coef($urandom_range(0, TableSize - 1), pick_coef());
        endcase
      end
      if (noise && $urandom_range(0, 29) == 0) send_request(make_request(KIND_DRAIN));
      send_request(make_request(KIND_PIXEL));
    end
    // pixels after the frame is in act as drains
    while (pixel_sb.results_made - start < total) begin
      it = make_request(($urandom_range(0, 3) == 0) ? KIND_PIXEL : KIND_DRAIN);
      send_request(it);
    end
    if ($urandom_range(0, 1) == 0) send_request(make_request(KIND_DRAIN));
  endtask

  // start of a large frame only; the next geometry write restarts it
  task automatic run_prefix(int unsigned kw, int unsigned kh, int unsigned w,
                            int unsigned h, int unsigned n_pix);
    settle();
    write_cfg(REG_KERNEL_WIDTH, 12'(kw));
    write_cfg(REG_KERNEL_HEIGHT, 12'(kh));
    write_cfg(REG_IMAGE_WIDTH, 12'(w));
    write_cfg(REG_IMAGE_HEIGHT, 12'(h));
    repeat (2) load_coef($urandom_range(0, TableSize - 1), pick_coef());
    repeat (n_pix) send_request(make_request(KIND_PIXEL));
  endtask

  initial begin
    int unsigned i, fw, fh;
    pixel_sb = new();
    idle_on = 1'b1;
    cycles = 0;
    rand_pixels = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset kernel size and all-zero coefficients
    write_cfg(REG_IMAGE_WIDTH, 12'd4);
    write_cfg(REG_IMAGE_HEIGHT, 12'd3);
    for (i = 0; i < 12; i++) send_request(make_request(KIND_PIXEL));
    for (i = 0; i < 12; i++) send_request(make_request(KIND_DRAIN));
    // extreme coefficients, indexes past the table, ignored kind
    load_coef(0, 16'h8000);
    load_coef(TableSize - 1, 16'h7fff);
    load_coef(TableSize, 16'h1234);
    load_coef(63, 16'hffff);
    send_request(make_request(KIND_NONE));
    settle();
    // unused register indexes change nothing
    for (i = 4; i < 8; i++) write_cfg(3'(i), 12'($urandom));

    // kernel wider than the image, even and zero sizes, out-of-range dims
    run_frame(7, 7, 3, 2, 49, 0);
    run_frame(0, 1, 5, 1, 4, 0);
    run_frame(2, 4, 4, 4, 8, 0);
    run_frame(6, 5, 2, 6, 8, 1);
    run_frame(1, 1, 0, 0, 2, 0);
    run_frame(7, 7, 1, 9, 8, 0);
    run_prefix(3, 1, 4095, 1, 24);
    run_prefix(3, 1, 2048, 2, 24);
    run_prefix(7, 7, 1, 4095, 24);

    // random frames, mostly small; no idling toward the end
    while (rand_pixels < 360) begin
      fw = $urandom_range(1, 24);
      fh = $urandom_range(1, 8);
      if (rand_pixels > 270) idle_on = 1'b0;
      run_frame($urandom_range(0, 7), $urandom_range(0, 7), fw, fh,
                $urandom_range(0, 10), 1);
      rand_pixels += fw * fh;
    end

    settle();
    foreach (pixel_sb.pending_q[j]) begin
      $error("expected pixel never came: col %0d row %0d",
             pixel_sb.pending_q[j].out_column, pixel_sb.pending_q[j].out_row);
      pixel_sb.errors++;
    end
    if (pixel_sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
